// ----- rtl/mqdd_pkg.sv -----
// Shared types, constants and the transition table of the quadrature detent decoder.
package mqdd_pkg;

  localparam int MAX_ENCODERS_DEF = 8;
  localparam int IDX_W            = 3;
  localparam int CFG_W            = 4;
  localparam int CNT_W            = 7;
  localparam int RES_W            = 3;
  localparam int SUM_W            = RES_W + 1;
  localparam int DETENT_COUNTS    = 4;

  typedef enum logic {
    MODE_INIT   = 1'b0,
    MODE_SAMPLE = 1'b1
  } mode_t;

  typedef struct packed {
    logic [1:0]              pins;
    logic signed [RES_W-1:0] residual;
  } entry_t;

  typedef struct packed {
    entry_t entry;
    logic   fire;
    logic   cw;
  } step_res_t;

  localparam entry_t ENTRY_RESET = '{pins: 2'b11, residual: '0};

  // Step of the x4 decode for a {previous, current} pin code.
  function automatic logic signed [1:0] step_of(input logic [3:0] code);
    logic signed [1:0] stp;
    unique case (code)
      4'd1, 4'd7, 4'd8, 4'd14:  stp = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: stp = 2'sd1;
      default:                  stp = 2'sd0;
    endcase
    return stp;
  endfunction

endpackage

// ----- rtl/multi_quadrature_detent_decoder_unit.sv -----
// Top level of the multi-encoder quadrature detent decoder.
// A request is held in stage one while its state word arrives from memory; a detent then goes to the output register.
// One request per cycle while in_stall is low, set by the read-modify-write of the
//   per-encoder state memory, with forwarding between back-to-back requests.
// Reset clears active_r and the memory valid bits; no clearing pass.
module multi_quadrature_detent_decoder_unit #(
  parameter int MAX_ENCODERS = mqdd_pkg::MAX_ENCODERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mqdd_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_mode,
  input  logic [mqdd_pkg::IDX_W-1:0] in_encoder_index,
  input  logic                       in_pin_a,
  input  logic                       in_pin_b,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mqdd_pkg::IDX_W-1:0] out_event_index,
  output logic                       out_clockwise
);
  import mqdd_pkg::*;

  localparam int AW = (MAX_ENCODERS > 1) ? $clog2(MAX_ENCODERS) : 1;

  // Configuration register; the port is always ready.
  logic [CFG_W-1:0] active_r, active_nxt;

  // Stage one: the request whose state word is arriving from memory.
  logic             s1_v_r, s1_v_nxt;
  logic             s1_act_r, s1_act_nxt;
  logic             s1_mode_r, s1_mode_nxt;
  logic [IDX_W-1:0] s1_idx_r, s1_idx_nxt;
  logic [AW-1:0]    s1_addr_r, s1_addr_nxt;
  logic [1:0]       s1_cur_r, s1_cur_nxt;

  // Forwarding of the word written in the same cycle the next request read memory.
  logic   fwd_hit_r, fwd_hit_nxt;
  entry_t fwd_data_r, fwd_data_nxt;

  // Output register.
  logic             out_v_r, out_v_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic             out_cw_r, out_cw_nxt;

  logic             accept;
  logic             s1_go;
  logic             wr_en;
  logic [AW-1:0]    in_addr;
  logic             in_act;
  logic [CNT_W-1:0] eff_count;
  entry_t           mem_rd;
  entry_t           old_entry;
  step_res_t        step;

  assign cfg_ready = 1'b1;

  // An encoder is active below both the configured count and the capacity.
  assign in_addr   = AW'(in_encoder_index);
  assign eff_count = (CNT_W'(active_r) > CNT_W'(MAX_ENCODERS)) ?
                     CNT_W'(MAX_ENCODERS) : CNT_W'(active_r);
  assign in_act    = (CNT_W'(in_encoder_index) < eff_count);

  // Stage one moves on unless it holds a detent and the output register is blocked.
  assign s1_go    = s1_v_r && !(step.fire && s1_act_r && out_v_r && out_stall);
  assign in_stall = s1_v_r && !s1_go;
  assign accept   = in_valid && !in_stall;
  assign wr_en    = s1_go && s1_act_r;

  mqdd_state_mem #(
    .DEPTH (MAX_ENCODERS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (step.entry),
    .rd_data (mem_rd)
  );

  // The word just written by the previous request is newer than what memory returned.
  assign old_entry = fwd_hit_r ? fwd_data_r : mem_rd;

  mqdd_step u_step (
    .mode      (s1_mode_r),
    .cur_pins  (s1_cur_r),
    .old_entry (old_entry),
    .res       (step)
  );

  always_comb begin
    active_nxt   = active_r;
    s1_v_nxt     = s1_v_r;
    s1_act_nxt   = s1_act_r;
    s1_mode_nxt  = s1_mode_r;
    s1_idx_nxt   = s1_idx_r;
    s1_addr_nxt  = s1_addr_r;
    s1_cur_nxt   = s1_cur_r;
    fwd_hit_nxt  = fwd_hit_r;
    fwd_data_nxt = fwd_data_r;
    out_v_nxt    = out_v_r;
    out_idx_nxt  = out_idx_r;
    out_cw_nxt   = out_cw_r;

    if (cfg_valid && cfg_ready) begin
      active_nxt = cfg_data;
    end

    if (accept) begin
      s1_v_nxt     = 1'b1;
      s1_act_nxt   = in_act;
      s1_mode_nxt  = in_mode;
      s1_idx_nxt   = in_encoder_index;
      s1_addr_nxt  = in_addr;
      s1_cur_nxt   = {in_pin_a, in_pin_b};
      fwd_hit_nxt  = wr_en && (s1_addr_r == in_addr);
      fwd_data_nxt = step.entry;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end

    if (s1_go && s1_act_r && step.fire) begin
      out_v_nxt   = 1'b1;
      out_idx_nxt = s1_idx_r;
      out_cw_nxt  = step.cw;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= '0;
      s1_v_r    <= 1'b0;
      fwd_hit_r <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      active_r  <= active_nxt;
      s1_v_r    <= s1_v_nxt;
      fwd_hit_r <= fwd_hit_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_act_r   <= s1_act_nxt;
    s1_mode_r  <= s1_mode_nxt;
    s1_idx_r   <= s1_idx_nxt;
    s1_addr_r  <= s1_addr_nxt;
    s1_cur_r   <= s1_cur_nxt;
    fwd_data_r <= fwd_data_nxt;
    out_idx_r  <= out_idx_nxt;
    out_cw_r   <= out_cw_nxt;
  end

  assign out_valid       = out_v_r;
  assign out_event_index = out_idx_r;
  assign out_clockwise   = out_cw_r;

`ifndef SYNTH
  // The input side only stalls behind a request held in stage one.
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r)
    else $error("input stalled with stage one empty");

  // Inactive encoders never write the state memory.
  a_write_active: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (s1_v_r && s1_act_r))
    else $error("state written for an inactive request");

  // Init requests never produce a detent.
  a_init_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_mode_r == MODE_INIT) |-> !step.fire)
    else $error("init request produced a detent");

  // A same-entry request right behind a write must take the forwarded word.
  a_forward: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && wr_en && (s1_addr_r == in_addr)) |=> (fwd_hit_r && s1_v_r))
    else $error("missing forward for back-to-back request");
`endif

endmodule

// ----- rtl/mqdd_state_mem.sv -----
// Per-encoder state memory with registered read and per-entry valid bits.
module mqdd_state_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  mqdd_pkg::entry_t wr_data,
  output mqdd_pkg::entry_t rd_data
);
  import mqdd_pkg::*;

  entry_t           mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  entry_t           rd_word_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // An entry never written since reset reads as its reset value.
  assign rd_data = rd_vld_r ? rd_word_r : ENTRY_RESET;

endmodule

// ----- rtl/mqdd_step.sv -----
// Transition decode and residual update for one encoder item.
module mqdd_step (
  input  logic                mode,
  input  logic [1:0]          cur_pins,
  input  mqdd_pkg::entry_t    old_entry,
  output mqdd_pkg::step_res_t res
);
  import mqdd_pkg::*;

  logic signed [1:0]       stp;
  logic signed [SUM_W-1:0] sum;
  logic                    up;
  logic                    dn;

  always_comb begin
    stp = step_of({old_entry.pins, cur_pins});
    sum = SUM_W'(old_entry.residual) + SUM_W'(stp);
    up  = (sum == SUM_W'(DETENT_COUNTS));
    dn  = (sum == -SUM_W'(DETENT_COUNTS));

    res.entry.pins = cur_pins;
    if (mode == MODE_INIT) begin
      res.entry.residual = '0;
      res.fire           = 1'b0;
      res.cw             = 1'b0;
    end else begin
      // The residual stays within three of zero, so a detent always returns it to zero.
      res.entry.residual = (up || dn) ? '0 : sum[RES_W-1:0];
      res.fire           = up || dn;
      res.cw             = up;
    end
  end

endmodule
